>>> hw/rtl/xor_checked_frame_receiver_assert.svh
`ifndef XOR_CHECKED_FRAME_RECEIVER_ASSERT_SVH
`define XOR_CHECKED_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define XCFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define XCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked during reset as well.
`define XCFR_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/xcfr_pkg.sv
package xcfr_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       abort;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  data_byte;
        logic [7:0]  command;
        logic [15:0] frame_len;
    } t_out_item;

    localparam logic [2:0] PH_CMD   = 3'd0;
    localparam logic [2:0] PH_LENHI = 3'd1;
    localparam logic [2:0] PH_LENLO = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_SUM   = 3'd4;

    localparam logic [2:0] EV_HEADER = 3'd0;
    localparam logic [2:0] EV_DATA   = 3'd1;
    localparam logic [2:0] EV_OK     = 3'd2;
    localparam logic [2:0] EV_BADSUM = 3'd3;
    localparam logic [2:0] EV_LONG   = 3'd4;
    localparam logic [2:0] EV_ABORT  = 3'd5;

    localparam logic [15:0] MAX_LEN_RESET = 16'd256;

endpackage

>>> hw/rtl/xcfr_in_stage.sv
module xcfr_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  xcfr_pkg::t_in_item i_item,
    input  logic              i_take,
    output logic              o_valid,
    output xcfr_pkg::t_in_item o_item
);

    logic               r_valid;
    xcfr_pkg::t_in_item r_item;

    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

>>> hw/rtl/xcfr_parser.sv
module xcfr_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_take,
    input  xcfr_pkg::t_in_item  i_item,
    output xcfr_pkg::t_out_item o_result
);

    logic [15:0] r_max;
    logic [2:0]  r_phase;
    logic [7:0]  r_cmd;
    logic [15:0] r_len;
    logic [15:0] r_left;
    logic [7:0]  r_xor;

    logic [2:0]  n_phase;
    logic [7:0]  n_cmd;
    logic [15:0] n_len;
    logic [15:0] n_left;
    logic [7:0]  n_xor;
    logic [2:0]  ev_kind;
    logic [7:0]  ev_data;
    logic [7:0]  b;
    logic [15:0] len_full;
    logic [15:0] left_dec;

    assign b        = i_item.rx_byte;
    assign len_full = {r_len[15:8], b};
    assign left_dec = r_left - 16'd1;

    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_left  = r_left;
        n_xor   = r_xor;
        ev_kind = xcfr_pkg::EV_HEADER;
        ev_data = 8'd0;
        if (i_item.abort) begin
            n_phase = xcfr_pkg::PH_CMD;
            n_left  = 16'd0;
            n_xor   = 8'd0;
            ev_kind = xcfr_pkg::EV_ABORT;
        end else begin
            unique case (r_phase)
                xcfr_pkg::PH_LENHI: begin
                    n_len   = {b, 8'd0};
                    n_xor   = r_xor ^ b;
                    n_phase = xcfr_pkg::PH_LENLO;
                end
                xcfr_pkg::PH_LENLO: begin
                    n_len = len_full;
                    n_xor = r_xor ^ b;
                    if (len_full > r_max) begin
                        n_phase = xcfr_pkg::PH_CMD;
                        n_left  = 16'd0;
                        ev_kind = xcfr_pkg::EV_LONG;
                    end else begin
                        n_left  = len_full;
                        n_phase = (len_full == 16'd0) ? xcfr_pkg::PH_SUM
                                                      : xcfr_pkg::PH_DATA;
                    end
                end
                xcfr_pkg::PH_DATA: begin
                    n_xor   = r_xor ^ b;
                    n_left  = left_dec;
                    if (left_dec == 16'd0) begin
                        n_phase = xcfr_pkg::PH_SUM;
                    end
                    ev_kind = xcfr_pkg::EV_DATA;
                    ev_data = b;
                end
                xcfr_pkg::PH_SUM: begin
                    n_phase = xcfr_pkg::PH_CMD;
                    ev_kind = (b == r_xor) ? xcfr_pkg::EV_OK : xcfr_pkg::EV_BADSUM;
                    n_xor   = 8'd0;
                end
                default: begin
                    n_cmd   = b;
                    n_len   = 16'd0;
                    n_left  = 16'd0;
                    n_xor   = b;
                    n_phase = xcfr_pkg::PH_LENHI;
                end
            endcase
        end
    end

    assign o_result.event_kind = ev_kind;
    assign o_result.data_byte  = ev_data;
    assign o_result.command    = n_cmd;
    assign o_result.frame_len  = n_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= xcfr_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= xcfr_pkg::PH_CMD;
            r_cmd   <= 8'd0;
            r_len   <= 16'd0;
            r_left  <= 16'd0;
            r_xor   <= 8'd0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_left  <= n_left;
            r_xor   <= n_xor;
        end
    end

endmodule

>>> hw/rtl/xcfr_out_stage.sv
module xcfr_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  xcfr_pkg::t_out_item i_result,
    output logic                o_valid,
    input  logic                i_stall,
    output xcfr_pkg::t_out_item o_item,
    output logic                o_free
);

    logic                r_valid;
    xcfr_pkg::t_out_item r_item;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_result;
        end
    end

endmodule

>>> hw/rtl/xor_checked_frame_receiver.sv
// Channel  Direction  Handshake               Payload
// input    in         i_in_valid / o_in_stall   i_in_item  (rx_byte, abort)
// output   out        o_out_valid / i_out_stall o_out_item (event_kind, data_byte,
//                                                           command, frame_len)
// config   in         i_cfg_we                i_cfg_wdata (length limit)
//
// One item per cycle sustained unless the output stalls; each item gives one result.
// The frame state updates as an item moves from the input register to the result register.
// Synchronous reset clears the frame state and loads a length limit of 256.
// A stall on the output holds the result register, then the input register, then stalls input.
module xor_checked_frame_receiver (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  xcfr_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output xcfr_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata
);

    logic                stg_valid;
    xcfr_pkg::t_in_item  stg_item;
    logic                out_free;
    logic                take;
    xcfr_pkg::t_out_item result;

    assign take = stg_valid && out_free;

    xcfr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .i_take  (take),
        .o_valid (stg_valid),
        .o_item  (stg_item)
    );

    xcfr_parser u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take),
        .i_item      (stg_item),
        .o_result    (result)
    );

    xcfr_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_result (result),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_item   (o_out_item),
        .o_free   (out_free)
    );

endmodule

>>> hw/rtl/xcfr_checker.sv
`include "xor_checked_frame_receiver_assert.svh"

module xcfr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input xcfr_pkg::t_out_item o_out_item
);

    `XCFR_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "output valid after reset")

    `XCFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "stalled result changed")

    `XCFR_ASSERT_NOW(a_kind_range, i_clk, i_rst_n, o_out_valid, o_out_item.event_kind <= xcfr_pkg::EV_ABORT, "event kind out of range")

    `XCFR_ASSERT_NOW(a_data_zero, i_clk, i_rst_n, o_out_valid && (o_out_item.event_kind != xcfr_pkg::EV_DATA), o_out_item.data_byte == 8'd0, "data byte set outside payload")

    `XCFR_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled without output stall")

endmodule

bind xor_checked_frame_receiver xcfr_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

>>> tb/tb_xor_checked_frame_receiver.sv
module tb_xor_checked_frame_receiver;

    typedef struct packed {
        logic [7:0]          b;
        logic                ab;
        logic                pinned;
        xcfr_pkg::t_out_item ev;
    } t_row;

    localparam t_row DIRECTED [23] = '{
        {8'h00, 1'b1, 1'b1, xcfr_pkg::EV_ABORT,  8'h00, 8'h00, 16'h0000},
        {8'hFF, 1'b0, 1'b1, xcfr_pkg::EV_HEADER, 8'h00, 8'hFF, 16'h0000},
        {8'h00, 1'b0, 1'b1, xcfr_pkg::EV_HEADER, 8'h00, 8'hFF, 16'h0000},
        {8'h00, 1'b0, 1'b1, xcfr_pkg::EV_HEADER, 8'h00, 8'hFF, 16'h0000},
        {8'hFF, 1'b0, 1'b1, xcfr_pkg::EV_OK,     8'h00, 8'hFF, 16'h0000},
        {8'h00, 1'b0, 1'b1, xcfr_pkg::EV_HEADER, 8'h00, 8'h00, 16'h0000},
        {8'h01, 1'b0, 1'b1, xcfr_pkg::EV_HEADER, 8'h00, 8'h00, 16'h0100},
        {8'h01, 1'b0, 1'b1, xcfr_pkg::EV_LONG,   8'h00, 8'h00, 16'h0101},
        {8'hA5, 1'b0, 1'b0, 35'h0},
        {8'h00, 1'b0, 1'b0, 35'h0},
        {8'h02, 1'b0, 1'b0, 35'h0},
        {8'hFF, 1'b0, 1'b1, xcfr_pkg::EV_DATA,   8'hFF, 8'hA5, 16'h0002},
        {8'h00, 1'b0, 1'b1, xcfr_pkg::EV_DATA,   8'h00, 8'hA5, 16'h0002},
        {8'h00, 1'b0, 1'b1, xcfr_pkg::EV_BADSUM, 8'h00, 8'hA5, 16'h0002},
        {8'h3C, 1'b0, 1'b0, 35'h0},
        {8'h00, 1'b0, 1'b0, 35'h0},
        {8'h01, 1'b0, 1'b0, 35'h0},
        {8'hFF, 1'b1, 1'b1, xcfr_pkg::EV_ABORT,  8'h00, 8'h3C, 16'h0001},
        {8'h01, 1'b0, 1'b0, 35'h0},
        {8'h01, 1'b0, 1'b0, 35'h0},
        {8'h00, 1'b0, 1'b1, xcfr_pkg::EV_HEADER, 8'h00, 8'h01, 16'h0100},
        {8'h7E, 1'b0, 1'b0, 35'h0},
        {8'h00, 1'b1, 1'b1, xcfr_pkg::EV_ABORT,  8'h00, 8'h01, 16'h0100}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    xcfr_pkg::t_in_item  i_in_item;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    xcfr_pkg::t_out_item o_out_item;
    logic                i_cfg_we;
    logic [15:0]         i_cfg_wdata;

    logic                pin_en;
    xcfr_pkg::t_out_item pin_ev;
    logic                quiet;
    int                  sent_cnt;
    int                  mismatch_cnt;

    logic [2:0]          rx_phase;
    logic [7:0]          cur_cmd;
    logic [15:0]         cur_len;
    logic [15:0]         left_cnt;
    logic [7:0]          sum_acc;
    logic [15:0]         len_limit;

    xcfr_pkg::t_out_item frame_event_q [$];

    xor_checked_frame_receiver uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic xcfr_pkg::t_out_item next_frame_event(input xcfr_pkg::t_in_item it);
        logic [2:0] kind;
        logic [7:0] data;
        kind = xcfr_pkg::EV_HEADER;
        data = 8'h00;
        if (it.abort) begin
            rx_phase = xcfr_pkg::PH_CMD;
            left_cnt = 16'h0000;
            sum_acc  = 8'h00;
            kind     = xcfr_pkg::EV_ABORT;
        end else begin
            case (rx_phase)
                xcfr_pkg::PH_LENHI: begin
                    cur_len  = {it.rx_byte, 8'h00};
                    sum_acc  = sum_acc ^ it.rx_byte;
                    rx_phase = xcfr_pkg::PH_LENLO;
                end
                xcfr_pkg::PH_LENLO: begin
                    cur_len = cur_len | {8'h00, it.rx_byte};
                    sum_acc = sum_acc ^ it.rx_byte;
                    if (cur_len > len_limit) begin
                        rx_phase = xcfr_pkg::PH_CMD;
                        left_cnt = 16'h0000;
                        kind     = xcfr_pkg::EV_LONG;
                    end else begin
                        left_cnt = cur_len;
                        rx_phase = (cur_len == 16'h0000) ? xcfr_pkg::PH_SUM
                                                         : xcfr_pkg::PH_DATA;
                    end
                end
                xcfr_pkg::PH_DATA: begin
                    sum_acc  = sum_acc ^ it.rx_byte;
                    left_cnt = left_cnt - 16'd1;
                    if (left_cnt == 16'h0000) rx_phase = xcfr_pkg::PH_SUM;
                    kind = xcfr_pkg::EV_DATA;
                    data = it.rx_byte;
                end
                xcfr_pkg::PH_SUM: begin
                    rx_phase = xcfr_pkg::PH_CMD;
                    kind     = (it.rx_byte == sum_acc) ? xcfr_pkg::EV_OK
                                                       : xcfr_pkg::EV_BADSUM;
                    sum_acc  = 8'h00;
                end
                default: begin
                    cur_cmd  = it.rx_byte;
                    cur_len  = 16'h0000;
                    left_cnt = 16'h0000;
                    sum_acc  = it.rx_byte;
                    rx_phase = xcfr_pkg::PH_LENHI;
                end
            endcase
        end
        return {kind, data, cur_cmd, cur_len};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin : monitor
        xcfr_pkg::t_out_item pred;
        xcfr_pkg::t_out_item want;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            pred = next_frame_event(i_in_item);
            frame_event_q.push_back(pin_en ? pin_ev : pred);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frame_event_q.size() == 0) begin
                report_mismatch($sformatf("unexpected item %h", o_out_item));
            end else begin
                want = frame_event_q.pop_front();
                if (o_out_item.event_kind !== want.event_kind)
                    report_mismatch($sformatf("event_kind got %0d want %0d",
                        o_out_item.event_kind, want.event_kind));
                if (o_out_item.data_byte !== want.data_byte)
                    report_mismatch($sformatf("data_byte got %h want %h",
                        o_out_item.data_byte, want.data_byte));
                if (o_out_item.command !== want.command)
                    report_mismatch($sformatf("command got %h want %h",
                        o_out_item.command, want.command));
                if (o_out_item.frame_len !== want.frame_len)
                    report_mismatch($sformatf("frame_len got %h want %h",
                        o_out_item.frame_len, want.frame_len));
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 17);
    end

    task automatic send_byte(input logic [7:0] b, input logic ab,
                             input logic pinned, input xcfr_pkg::t_out_item ev);
        while (!quiet && $urandom_range(99) < 17) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item  = {b, ab};
        pin_en     = pinned;
        pin_ev     = ev;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_cnt++;
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        logic [7:0]  cmd;
        logic [7:0]  sum;
        logic [7:0]  b;
        logic [15:0] len;
        int          cut;
        int          r;
        r = $urandom_range(99);
        if (r < 60)
            len = 16'($urandom_range(8));
        else if (r < 75)
            len = (len_limit < 16'd40) ? len_limit + 16'($urandom_range(1))
                                       : 16'($urandom_range(40));
        else
            len = 16'($urandom);
        cut = ($urandom_range(99) < 6) ? int'($urandom_range(int'(len) + 3)) : -1;
        if (len > 16'd32 && len <= len_limit) cut = 3 + int'($urandom_range(4));
        cmd = 8'($urandom);
        sum = cmd ^ len[15:8] ^ len[7:0];
        for (int k = 0; k < int'(len) + 4; k++) begin
            if (k == cut) begin
                send_byte(8'($urandom), 1'b1, 1'b0, '0);
                return;
            end
            if (k == 0)
                b = cmd;
            else if (k == 1)
                b = len[15:8];
            else if (k == 2)
                b = len[7:0];
            else if (k < int'(len) + 3) begin
                b   = 8'($urandom);
                sum = sum ^ b;
            end else
                b = ($urandom_range(99) < 80) ? sum : 8'($urandom);
            send_byte(b, 1'b0, 1'b0, '0);
            if (k == 2 && len > len_limit) return;
        end
    endtask

    initial begin
        int target;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = 16'h0000;
        pin_en       = 1'b0;
        pin_ev       = '0;
        quiet        = 1'b0;
        sent_cnt     = 0;
        mismatch_cnt = 0;
        rx_phase     = xcfr_pkg::PH_CMD;
        cur_cmd      = 8'h00;
        cur_len      = 16'h0000;
        left_cnt     = 16'h0000;
        sum_acc      = 8'h00;
        len_limit    = xcfr_pkg::MAX_LEN_RESET;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i].b, DIRECTED[i].ab, DIRECTED[i].pinned, DIRECTED[i].ev);

        for (int ph = 0; ph < 5; ph++) begin
            i_in_valid = 1'b0;
            wait (frame_event_q.size() == 0);
            repeat (3) @(negedge i_clk);
            case (ph)
                0: i_cfg_wdata = 16'hFFFF;
                1: i_cfg_wdata = 16'h0000;
                2: i_cfg_wdata = 16'h0005;
                3: i_cfg_wdata = 16'($urandom);
                default: i_cfg_wdata = xcfr_pkg::MAX_LEN_RESET;
            endcase
            i_cfg_we  = 1'b1;
            len_limit = i_cfg_wdata;
            @(negedge i_clk);
            i_cfg_we = 1'b0;
            quiet    = (ph == 2);
            target   = sent_cnt + 100;
            while (sent_cnt < target) begin
                if ($urandom_range(9) == 0)
                    send_byte(8'($urandom), $urandom_range(99) < 30, 1'b0, '0);
                else
                    send_frame();
            end
        end

        i_in_valid = 1'b0;
        quiet      = 1'b0;
        wait (frame_event_q.size() == 0);
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && frame_event_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/xcfr_pkg.sv
hw/rtl/xcfr_in_stage.sv
hw/rtl/xcfr_parser.sv
hw/rtl/xcfr_out_stage.sv
hw/rtl/xor_checked_frame_receiver.sv
hw/rtl/xcfr_checker.sv
tb/tb_xor_checked_frame_receiver.sv
